### hdl/mavc_pkg.sv
package mavc_pkg;

  // default sizes of the sample ring
  localparam int unsigned MAX_WINDOW_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned CFG_W = 7;
  localparam int unsigned VAR_W = 32;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd64;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CHECK = 1'b1
  } opcode_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/mavc_store.sv
module mavc_store #(
  parameter int unsigned DEPTH  = mavc_pkg::MAX_WINDOW_DEF,
  parameter int unsigned DATA_W = mavc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);
  import mavc_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DEPTH-1:0]  vld_q;
  logic              rd_vld_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

### hdl/mavc_div.sv
module mavc_div #(
  parameter int unsigned N  = 53,
  parameter int unsigned DW = 21
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [$clog2(N+1)-1:0]   iters_i,
  input  logic [N-1:0]             dividend_i,
  input  logic [DW-1:0]            divisor_i,
  output mavc_pkg::div_stat_t      stat_o,
  output logic [N-1:0]             quot_o
);
  import mavc_pkg::*;

  localparam int unsigned CW = $clog2(N+1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW-1:0] rem_q;
  logic [N-1:0]  q_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_nx;
  logic          ge;

  // one quotient bit per clock, dividend shifted out from the top
  always_comb begin
    rem_sh = {rem_q, q_q[N-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= iters_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      q_q   <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_nx[DW-1:0];
      q_q   <= {q_q[N-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = q_q;

endmodule

### hdl/moving_average_with_variance_check_unit.sv
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------------------------
// in       | in        | in_valid_i / in_stall_o | opcode_i, sample_i
// out      | out       | out_valid_o/out_stall_i | filtered_value_o, variance_o, steady_flag_o
// cfg      | in        | cfg_valid_i/cfg_ready_o | window_size_i
//
// push: paced by the restoring divider, which retires one quotient bit per clock
// check: for each ring entry in turn, read, W*x, |W*x - S| and the square in two
//   halves via the single store read port and the split squaring multiplier, then two divides
// reset: ring entries read as zero through per-entry valid bits, no clearing pass
// one beat in flight; the output register lets the next beat in while a result waits
module moving_average_with_variance_check_unit #(
  parameter int unsigned MAX_WINDOW  = mavc_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = mavc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mavc_pkg::CFG_W-1:0]    window_size_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_value_o,
  output logic [mavc_pkg::VAR_W-1:0]    variance_o,
  output logic                          steady_flag_o
);
  import mavc_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_WINDOW);      // ring index
  localparam int unsigned WW   = $clog2(MAX_WINDOW + 1);  // window / fill count
  localparam int unsigned SW   = SAMPLE_BITS + AW;        // running sum, signed
  localparam int unsigned PW   = WW + SAMPLE_BITS + 1;    // W*x and W*x - S, signed
  localparam int unsigned DMW  = PW - 1;                  // |W*x - S|
  localparam int unsigned HL   = (DMW + 1) / 2;           // low half of the squaring split
  localparam int unsigned PRW  = DMW + HL;                // partial product
  localparam int unsigned SQW  = 2 * DMW;                 // S squared
  localparam int unsigned ACW  = SQW + WW;                // deviation accumulator
  localparam int unsigned LW   = ACW + 4;                 // 10 * accumulator
  localparam int unsigned W2W  = 2 * WW;
  localparam int unsigned DVS  = 3 * WW;                  // W cubed
  localparam int unsigned CW   = $clog2(ACW + 1);
  localparam int unsigned CMPW = (WW > CFG_W) ? WW : CFG_W;
  localparam int unsigned QXW  = (ACW > VAR_W) ? ACW : VAR_W + 1;

  localparam logic [SW-1:0] POS_LIM =
    {{(SW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SW-1:0] NEG_LIM = POS_LIM + SW'(1);
  localparam logic [SAMPLE_BITS-1:0] FV_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] FV_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_P_RMW = 18'h00002,  // old entry back from the store, update sum, write new
    ST_P_DGO = 18'h00004,
    ST_P_DWT = 18'h00008,
    ST_C_RD  = 18'h00010,  // read ring entry i
    ST_C_WX  = 18'h00020,  // W * x
    ST_C_DF  = 18'h00040,  // |W*x - S|
    ST_C_ML  = 18'h00080,  // square, low half
    ST_C_MH  = 18'h00100,  // square, high half
    ST_C_SL  = 18'h00200,  // S squared, low half
    ST_C_SH  = 18'h00400,  // S squared, high half
    ST_C_RH  = 18'h00800,
    ST_C_CMP = 18'h01000,
    ST_C_FGO = 18'h02000,  // mean divide
    ST_C_FWT = 18'h04000,
    ST_C_VGO = 18'h08000,  // variance divide
    ST_C_VWT = 18'h10000,
    ST_FIN   = 18'h20000   // hand result to the output register
  } state_e;

  state_e                  state_q, state_d;
  logic [CFG_W-1:0]        win_q, win_d;
  logic [AW-1:0]           ptr_q, ptr_d;
  logic [WW-1:0]           fill_q, fill_d;
  logic signed [SW-1:0]    sum_q, sum_d;
  logic                    out_valid_q, out_valid_d;

  logic [WW-1:0]           w_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [AW-1:0]           i_q;
  logic signed [PW-1:0]    wx_q;
  logic [DMW-1:0]          d_q;
  logic [ACW-1:0]          acc_q;
  logic [SQW-1:0]          s2_q;
  logic [ACW-1:0]          rhs_q;
  logic [LW-1:0]           lhs_q;
  logic [W2W-1:0]          w2_q;
  logic [DVS-1:0]          w3_q;
  logic [SAMPLE_BITS-1:0]  res_fv_q;
  logic [VAR_W-1:0]        res_var_q;
  logic                    res_st_q;
  logic [SAMPLE_BITS-1:0]  out_fv_q;
  logic [VAR_W-1:0]        out_var_q;
  logic                    out_st_q;

  logic [WW-1:0]           weff;
  logic [WW-1:0]           nxt_w;
  logic [AW-1:0]           nxt_ptr;
  logic                    accept;
  logic                    load_out;
  logic                    last_i;
  logic [SW-1:0]           sabs;
  logic signed [PW-1:0]    diff;
  logic [DMW-1:0]          dabs;
  logic [HL-1:0]           mul_b;
  logic [PRW-1:0]          prod;
  logic [SAMPLE_BITS-1:0]  rd_data;
  logic signed [SAMPLE_BITS-1:0] x_rd;
  logic                    mem_we;
  logic [AW-1:0]           mem_raddr;

  logic                    div_start;
  logic [CW-1:0]           div_iters;
  logic [ACW-1:0]          div_dividend;
  logic [DVS-1:0]          div_divisor;
  div_stat_t               div_stat;
  logic [ACW-1:0]          div_quot;
  logic [QXW-1:0]          quot_x;
  logic [VAR_W-1:0]        var_sat;

  // signed mean from quotient magnitude, saturated to the sample range
  function automatic logic [SAMPLE_BITS-1:0] sat_fv(input logic [SW-1:0] mag,
                                                    input logic neg);
    logic [SAMPLE_BITS-1:0] r;
    if (neg) begin
      if (mag > NEG_LIM) r = FV_MIN;
      else r = SAMPLE_BITS'(0) - mag[SAMPLE_BITS-1:0];
    end else begin
      if (mag > POS_LIM) r = FV_MAX;
      else r = mag[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // effective window: zero reads as one, oversize clamps to the ring depth
  always_comb begin
    if (win_q == '0) begin
      weff = WW'(1);
    end else if (CMPW'(win_q) > CMPW'(MAX_WINDOW)) begin
      weff = WW'(MAX_WINDOW);
    end else begin
      weff = WW'(win_q);
    end
  end

  // pointer advances before the write, wraps at the window
  assign nxt_w   = WW'(ptr_q) + WW'(1);
  assign nxt_ptr = (nxt_w >= weff) ? '0 : AW'(nxt_w);

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign load_out    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign last_i      = (WW'(i_q) + WW'(1)) == w_q;

  assign sabs = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign diff = wx_q - PW'(sum_q);
  assign dabs = diff[PW-1] ? DMW'(-diff) : DMW'(diff);

  // square split in two halves so one product stays narrow
  assign mul_b = ((state_q == ST_C_MH) || (state_q == ST_C_SH)) ?
                 HL'(d_q[DMW-1:HL]) : d_q[HL-1:0];
  assign prod  = PRW'(d_q) * PRW'(mul_b);

  assign x_rd = signed'(rd_data);

  // ring store; one beat at a time, so the write never meets a pending read
  assign mem_we    = (state_q == ST_P_RMW);
  assign mem_raddr = (state_q == ST_IDLE) ? nxt_ptr : i_q;

  mavc_store #(
    .DEPTH  (MAX_WINDOW),
    .DATA_W (SAMPLE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (ptr_q),
    .wdata_i (x_q),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  // shared divider: sum by fill or window, deviation sum by W cubed
  assign div_start    = (state_q == ST_P_DGO) || (state_q == ST_C_FGO) ||
                        (state_q == ST_C_VGO);
  assign div_dividend = (state_q == ST_C_VGO) ? acc_q : (ACW'(sabs) << (ACW - SW));
  assign div_iters    = (state_q == ST_C_VGO) ? CW'(ACW) : CW'(SW);

  always_comb begin
    if (state_q == ST_P_DGO) begin
      div_divisor = DVS'(fill_q);
    end else if (state_q == ST_C_FGO) begin
      div_divisor = DVS'(w_q);
    end else begin
      div_divisor = w3_q;
    end
  end

  mavc_div #(
    .N  (ACW),
    .DW (DVS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .iters_i    (div_iters),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // variance saturates to all ones
  assign quot_x  = QXW'(div_quot);
  assign var_sat = (|quot_x[QXW-1:VAR_W]) ? '1 : quot_x[VAR_W-1:0];

  // sequencer and architectural state
  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;

    if (cfg_valid_i && cfg_ready_o) begin
      win_d = window_size_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_e'(opcode_i) == OP_CHECK) begin
            state_d = ST_C_RD;
          end else begin
            fill_d  = (fill_q < weff) ? fill_q + WW'(1) : fill_q;
            ptr_d   = nxt_ptr;
            state_d = ST_P_RMW;
          end
        end
      end
      ST_P_RMW: begin
        sum_d   = sum_q + SW'(x_q) - SW'(x_rd);
        state_d = ST_P_DGO;
      end
      ST_P_DGO: state_d = ST_P_DWT;
      ST_P_DWT: begin
        if (div_stat.done) state_d = ST_FIN;
      end
      ST_C_RD:  state_d = ST_C_WX;
      ST_C_WX:  state_d = ST_C_DF;
      ST_C_DF:  state_d = ST_C_ML;
      ST_C_ML:  state_d = ST_C_MH;
      ST_C_MH: begin
        state_d = last_i ? ST_C_SL : ST_C_RD;
      end
      ST_C_SL:  state_d = ST_C_SH;
      ST_C_SH:  state_d = ST_C_RH;
      ST_C_RH:  state_d = ST_C_CMP;
      ST_C_CMP: state_d = ST_C_FGO;
      ST_C_FGO: state_d = ST_C_FWT;
      ST_C_FWT: begin
        if (div_stat.done) state_d = ST_C_VGO;
      end
      ST_C_VGO: state_d = ST_C_VWT;
      ST_C_VWT: begin
        if (div_stat.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WINDOW_RESET;
      ptr_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= sample_i;
      w_q   <= weff;
      i_q   <= '0;
      acc_q <= '0;
    end
    case (state_q)
      ST_C_WX: wx_q <= PW'($signed({1'b0, w_q})) * PW'(x_rd);
      ST_C_DF: d_q  <= dabs;
      ST_C_ML: acc_q <= acc_q + ACW'(prod);
      ST_C_MH: begin
        acc_q <= acc_q + (ACW'(prod) << HL);
        if (last_i) begin
          d_q <= DMW'(sabs);
        end else begin
          i_q <= i_q + AW'(1);
        end
      end
      ST_C_SL: s2_q <= SQW'(prod);
      ST_C_SH: s2_q <= s2_q + (SQW'(prod) << HL);
      ST_C_RH: begin
        // steady test: 10 * sum of squared deviations against W * S^2
        rhs_q <= ACW'(s2_q) * ACW'(w_q);
        lhs_q <= (LW'(acc_q) << 3) + (LW'(acc_q) << 1);
        w2_q  <= W2W'(w_q) * W2W'(w_q);
      end
      ST_C_CMP: begin
        res_st_q <= LW'(rhs_q) > lhs_q;
        w3_q     <= DVS'(w2_q) * DVS'(w_q);
      end
      ST_P_DWT: begin
        if (div_stat.done) begin
          res_fv_q  <= sat_fv(div_quot[SW-1:0], sum_q[SW-1]);
          res_var_q <= '0;
          res_st_q  <= 1'b0;
        end
      end
      ST_C_FWT: begin
        if (div_stat.done) res_fv_q <= sat_fv(div_quot[SW-1:0], sum_q[SW-1]);
      end
      ST_C_VWT: begin
        if (div_stat.done) res_var_q <= var_sat;
      end
      default: ;
    endcase
    if (load_out) begin
      out_fv_q  <= res_fv_q;
      out_var_q <= res_var_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = signed'(out_fv_q);
  assign variance_o       = out_var_q;
  assign steady_flag_o    = out_st_q;

endmodule

### hdl/mavc_check.sv
module mavc_check #(
  parameter int unsigned SAMPLE_BITS = mavc_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_i,
  input logic                          out_valid_i,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] filtered_value_i,
  input logic [mavc_pkg::VAR_W-1:0]    variance_i,
  input logic                          steady_flag_i
);

  logic [1:0] pend_q;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid_i && !in_stall_i;
  assign out_beat = out_valid_i && !out_stall_i;

  // beats taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_beat && !out_beat) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_beat && !in_beat) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(filtered_value_i) &&
      $stable(variance_i) && $stable(steady_flag_i))
    else $error("stalled result changed");

  ap_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_i)
    else $error("input taken again right after a beat");

  ap_out_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != 2'd0))
    else $error("result without a pending item");

  ap_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items pending");

endmodule

bind moving_average_with_variance_check_unit mavc_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mavc_check (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .filtered_value_i (filtered_value_o),
  .variance_i       (variance_o),
  .steady_flag_i    (steady_flag_o)
);

### test/tb_moving_average_with_variance_check_unit.sv
`timescale 1ns / 1ps

module tb_moving_average_with_variance_check_unit;
  import mavc_pkg::*;

  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int MAX_W = MAX_WINDOW_DEF;

  localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

  // steady means 10 * sum of squared deviations below W * S^2
  localparam int unsigned STEADY_RATIO = 10;

  localparam int RANDOM_BEATS = 1200;

  typedef enum logic [1:0] {
    SMP_FULL,
    SMP_STEADY,
    SMP_EXTREME,
    SMP_NARROW
  } sample_style_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct {
    opcode_e              op;
    logic signed [SB-1:0] smp;
  } feed_beat_t;

  typedef struct {
    logic signed [SB-1:0] avg;
    logic [VAR_W-1:0]     var_val;
    logic                 steady;
  } win_stats_t;

  // clock, reset and block-side signals; those the bench drives are known from time zero
  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic                 opcode      = OP_PUSH;
  logic signed [SB-1:0] sample      = '0;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     window_size = WINDOW_RESET;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic signed [SB-1:0] filtered_value;
  logic [VAR_W-1:0]     variance;
  logic                 steady_flag;

  moving_average_with_variance_check_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .sample_i        (sample),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .window_size_i   (window_size),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .filtered_value_o(filtered_value),
    .variance_o      (variance),
    .steady_flag_o   (steady_flag)
  );

  // beats waiting to be driven, and window stats waiting to come out
  feed_beat_t sample_feed_q[$];
  win_stats_t stats_due_q[$];
  int         mismatches = 0;

  // shadow copy of the ring filter state
  logic signed [SB-1:0] ring [MAX_W];
  int unsigned          wr_pos   = 0;
  int unsigned          fill_cnt = 0;
  longint               ring_sum = 0;
  logic [CFG_W-1:0]     win_reg  = WINDOW_RESET;

  initial begin
    for (int i = 0; i < MAX_W; i++) ring[i] = '0;
  end

  function automatic int unsigned eff_window(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_W) return MAX_W;
    return 32'(v);
  endfunction

  function automatic logic signed [SB-1:0] clamp_sample(longint v);
    if (v > longint'(SMP_MAX)) return SMP_MAX;
    if (v < longint'(SMP_MIN)) return SMP_MIN;
    return v[SB-1:0];
  endfunction

  // advance the shadow ring by one beat and work out the result it gives
  task automatic compute_window_stats(input logic op, input logic signed [SB-1:0] smp,
                                      output win_stats_t st);
    int unsigned  w;
    int unsigned  nxt;
    int unsigned  k;
    longint       d;
    logic [63:0]  dabs;
    logic [63:0]  sabs;
    logic [127:0] acc;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] w3;
    logic [127:0] quo;
    w = eff_window(win_reg);
    if (op == OP_PUSH) begin
      // pointer moves before the write, wraps once it reaches the window
      if (fill_cnt < w) fill_cnt++;
      nxt = wr_pos + 1;
      if (nxt >= w) nxt = 0;
      wr_pos = nxt;
      ring_sum += longint'(smp) - longint'(ring[nxt]);
      ring[nxt] = smp;
      st.avg     = clamp_sample(ring_sum / longint'(fill_cnt));
      st.var_val = '0;
      st.steady  = 1'b0;
    end else begin
      // sum includes entries outside the window, only the first w are walked
      acc = '0;
      for (k = 0; k < w; k++) begin
        d    = longint'(w) * longint'(ring[k]) - ring_sum;
        dabs = (d < 0) ? -d : d;
        acc += 128'(dabs) * 128'(dabs);
      end
      sabs = (ring_sum < 0) ? -ring_sum : ring_sum;
      lhs  = acc * STEADY_RATIO;
      rhs  = 128'(sabs) * 128'(sabs) * 128'(w);
      w3   = 128'(w) * 128'(w) * 128'(w);
      quo  = acc / w3;
      st.avg     = clamp_sample(ring_sum / longint'(w));
      st.var_val = (quo > 128'hFFFF_FFFF) ? '1 : quo[VAR_W-1:0];
      st.steady  = (lhs < rhs);
    end
  endtask

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // input driver, bursts with random gaps
  logic in_taken   = 1'b0;
  int   burst_left = 1;
  int   gap_left   = 0;

  always @(negedge clk) begin
    // a stalled beat holds its payload
    if (rst_n && !(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_feed_q.size() > 0) begin
        in_valid <= 1'b1;
        opcode   <= sample_feed_q[0].op;
        sample   <= sample_feed_q[0].smp;
        void'(sample_feed_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // a fair share of back-to-back bursts
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall pattern, switches to a random mode after each random span
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_span = 0;
  int          stall_tick = 0;

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_span == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_span <= $urandom_range(20, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 8);
      STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
      default:        out_stall <= 1'b0;
    endcase
  end

  // monitor: config writes, accepted input beats, accepted result beats
  always @(posedge clk) begin
    win_stats_t st;
    win_stats_t want;
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) win_reg = window_size;
      if (in_valid && !in_stall) begin
        compute_window_stats(opcode, sample, st);
        stats_due_q.push_back(st);
      end
      if (out_valid && !out_stall) begin
        if (stats_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: filtered %0d variance %0d steady %0b",
                     filtered_value, variance, steady_flag);
        end else begin
          want = stats_due_q.pop_front();
          if (filtered_value !== want.avg || variance !== want.var_val ||
              steady_flag !== want.steady) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: fv exp %0d got %0d, var exp %0d got %0d, st exp %0b got %0b",
                       want.avg, filtered_value, want.var_val, variance,
                       want.steady, steady_flag);
          end
        end
      end
    end
  end

  task automatic queue_beat(input opcode_e op, input logic signed [SB-1:0] smp);
    feed_beat_t b;
    b.op  = op;
    b.smp = smp;
    sample_feed_q.push_back(b);
  endtask

  // idle once every beat is driven and every result has come back
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (sample_feed_q.size() != 0 || in_valid || stats_due_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    @(negedge clk);
    cfg_valid   <= 1'b1;
    window_size <= w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SB-1:0] draw_sample(sample_style_e style,
                                                      logic signed [SB-1:0] base);
    logic [SB-1:0] raw;
    raw = SB'($urandom);
    case (style)
      // small spread around a base, the steady flag gets a chance
      SMP_STEADY: return base + SB'($urandom_range(0, 31)) - SB'(16);
      SMP_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return SMP_MAX;
          1:       return SMP_MIN;
          2:       return raw;
          default: return base;
        endcase
      end
      SMP_NARROW: return SB'($urandom_range(0, 255)) - SB'(128);
      default:    return raw;
    endcase
  endfunction

  int                   issued;
  int                   phase_len;
  int                   check_pct;
  int                   win_roll;
  logic [CFG_W-1:0]     win_pick;
  sample_style_e        style;
  logic signed [SB-1:0] base;

  initial begin
    repeat (5) @(posedge clk);
    #2 rst_n = 1'b1;

    // reset window: check of an empty ring, first push lands in slot 1
    queue_beat(OP_CHECK, SB'($urandom));
    queue_beat(OP_PUSH, SMP_MAX);
    queue_beat(OP_PUSH, SMP_MAX);
    queue_beat(OP_PUSH, SMP_MAX);
    queue_beat(OP_CHECK, SB'($urandom));
    wait_idle();

    // shrink to 2: stale entries stay in the sum, averages saturate
    write_window(7'd2);
    queue_beat(OP_PUSH, SMP_MAX);
    queue_beat(OP_CHECK, '0);
    queue_beat(OP_PUSH, SMP_MIN);
    queue_beat(OP_PUSH, SMP_MIN);
    queue_beat(OP_CHECK, '1);
    wait_idle();

    // window of one writes slot 0 only
    write_window(7'd1);
    queue_beat(OP_PUSH, SB'(-1));
    queue_beat(OP_CHECK, '0);
    wait_idle();

    // zero reads as one
    write_window(7'd0);
    queue_beat(OP_PUSH, SB'(5));
    queue_beat(OP_CHECK, '0);
    wait_idle();

    // above the ring size reads as full ring
    write_window(7'h7F);
    queue_beat(OP_PUSH, SMP_MIN);
    queue_beat(OP_CHECK, '0);
    wait_idle();

    write_window(7'd64);
    queue_beat(OP_PUSH, '0);
    queue_beat(OP_PUSH, SB'(1));
    queue_beat(OP_PUSH, SB'(-1));
    queue_beat(OP_CHECK, '0);
    wait_idle();

    // random phases, each under its own window and sample style
    issued = 0;
    while (issued < RANDOM_BEATS) begin
      win_roll = $urandom_range(0, 19);
      if (win_roll < 5)       win_pick = CFG_W'($urandom_range(1, 4));
      else if (win_roll < 10) win_pick = CFG_W'(MAX_W);
      else if (win_roll < 17) win_pick = CFG_W'($urandom_range(1, MAX_W));
      else if (win_roll < 18) win_pick = '0;
      else                    win_pick = CFG_W'($urandom_range(MAX_W + 1, 127));
      write_window(win_pick);

      phase_len = $urandom_range(40, 160);
      check_pct = $urandom_range(5, 35);
      style     = sample_style_e'($urandom_range(0, 3));
      base      = SB'($urandom);
      for (int n = 0; n < phase_len; n++) begin
        queue_beat(($urandom_range(0, 99) < check_pct) ? OP_CHECK : OP_PUSH,
                   draw_sample(style, base));
      end
      issued += phase_len;
      wait_idle();
    end

    // room for any stray result beat
    repeat (500) @(posedge clk);
    if (mismatches == 0 && stats_due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
hdl/mavc_pkg.sv
hdl/mavc_store.sv
hdl/mavc_div.sv
hdl/moving_average_with_variance_check_unit.sv
hdl/mavc_check.sv
test/tb_moving_average_with_variance_check_unit.sv
